>>> rtl/ggap_pkg.sv
// Package for the GGA sentence position parser: byte classes, weights, sizes.
`default_nettype none

package ggap_pkg;

	// Character codes the parser looks for
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_TWO    = 8'h32;

	// Field numbers (counted by commas) and coordinate formats
	localparam logic [3:0] FLD_LAT  = 4'd2;
	localparam logic [3:0] FLD_NS   = 4'd3;
	localparam logic [3:0] FLD_LON  = 4'd4;
	localparam logic [3:0] FLD_EW   = 4'd5;
	localparam logic [3:0] FLD_QUAL = 4'd6;
	localparam logic [3:0] FLD_MAX  = 4'd15;
	localparam logic [3:0] LAT_LEN  = 4'd9;
	localparam logic [3:0] LON_LEN  = 4'd10;
	localparam logic [3:0] LAT_DOT  = 4'd4;
	localparam logic [3:0] LON_DOT  = 4'd5;

	// Byte positions of the sentence type letters
	localparam logic [7:0] POS_T0   = 8'd2;
	localparam logic [7:0] POS_T1   = 8'd3;
	localparam logic [7:0] POS_T2   = 8'd4;
	localparam logic [7:0] MIN_BYTES = 8'd5;

	localparam int LAT_W  = 26;
	localparam int LON_W  = 30;
	localparam int TDATA_W = 64;

	// Fix quality codes
	localparam logic [1:0] FIX_NONE = 2'd0;
	localparam logic [1:0] FIX_GPS  = 2'd1;
	localparam logic [1:0] FIX_DGPS = 2'd2;

	localparam int MAX_SENTENCE_DEF = 255;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// One classified byte, as queued between front and back
	typedef struct packed {
		logic [3:0] digit;
		logic       is_digit;
		logic       is_dollar;
		logic       is_eol;
		logic       is_comma;
		logic       is_dot;
		logic       is_g;
		logic       is_a;
		logic       is_n;
		logic       is_e;
		logic       is_q1;
		logic       is_q2;
	} ggap_item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic       valid;
		ggap_item_t item;
	} ggap_head_t;

	// Weight of each latitude character in minutes * 1e4 (DDMM.MMMM)
	function automatic logic [LAT_W-1:0] lat_weight(input logic [3:0] off);
		logic [LAT_W-1:0] w;
		unique case (off)
			4'd0:    w = LAT_W'(6000000);
			4'd1:    w = LAT_W'(600000);
			4'd2:    w = LAT_W'(100000);
			4'd3:    w = LAT_W'(10000);
			4'd5:    w = LAT_W'(1000);
			4'd6:    w = LAT_W'(100);
			4'd7:    w = LAT_W'(10);
			4'd8:    w = LAT_W'(1);
			default: w = '0;
		endcase
		return w;
	endfunction

	// Weight of each longitude character in minutes * 1e4 (DDDMM.MMMM)
	function automatic logic [LON_W-1:0] lon_weight(input logic [3:0] off);
		logic [LON_W-1:0] w;
		unique case (off)
			4'd0:    w = LON_W'(60000000);
			4'd1:    w = LON_W'(6000000);
			4'd2:    w = LON_W'(600000);
			4'd3:    w = LON_W'(100000);
			4'd4:    w = LON_W'(10000);
			4'd6:    w = LON_W'(1000);
			4'd7:    w = LON_W'(100);
			4'd8:    w = LON_W'(10);
			4'd9:    w = LON_W'(1);
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ggap_front.sv
// Front end: accepts received bytes, drops NUL, classifies and queues them.
`default_nettype none

module ggap_front
	import ggap_pkg::*;
(
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	input  wire logic       q_full,
	output logic            in_ready,
	output logic            push,
	output ggap_item_t      item
);

	// Ready only on queue space
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full && (in_byte != CH_NUL);

	// Character classes
	always_comb begin
		item.is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		item.digit     = 4'(in_byte - CH_ZERO);
		item.is_dollar = (in_byte == CH_DOLLAR);
		item.is_eol    = (in_byte == CH_CR) || (in_byte == CH_LF);
		item.is_comma  = (in_byte == CH_COMMA);
		item.is_dot    = (in_byte == CH_DOT);
		item.is_g      = (in_byte == CH_G);
		item.is_a      = (in_byte == CH_A);
		item.is_n      = (in_byte == CH_N);
		item.is_e      = (in_byte == CH_E);
		item.is_q1     = (in_byte == CH_ONE);
		item.is_q2     = (in_byte == CH_TWO);
	end

endmodule

`default_nettype wire

>>> rtl/ggap_queue.sv
// Short FIFO of classified bytes between the front and back ends.
`default_nettype none

module ggap_queue
	import ggap_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire ggap_item_t push_item,
	input  wire logic       pop,
	output logic            full,
	output ggap_head_t      head
);

	ggap_item_t            mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_pop;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");

endmodule

`default_nettype wire

>>> rtl/ggap_back.sv
// Back end: sentence framing, field parsing and the result output register.
`default_nettype none

module ggap_back
	import ggap_pkg::*;
#(
	parameter int MAX_SENTENCE = MAX_SENTENCE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ggap_head_t         head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [TDATA_W-1:0]      out_data
);

	localparam logic [7:0] MaxCnt = 8'(MAX_SENTENCE);

	// Sentence state
	logic             open_q,      open_n;
	logic [7:0]       byte_cnt_q,  byte_cnt_n;
	logic [3:0]       fld_num_q,   fld_num_n;
	logic [3:0]       fld_off_q,   fld_off_n;
	logic             type_ok_q,   type_ok_n;
	logic [LAT_W-1:0] lat_acc_q,   lat_acc_n;
	logic [LON_W-1:0] lon_acc_q,   lon_acc_n;
	logic             lat_ok_q,    lat_ok_n;
	logic             lon_ok_q,    lon_ok_n;
	logic             north_q,     north_n;
	logic             east_q,      east_n;
	logic [1:0]       qual_q,      qual_n;

	// Output register
	logic               out_valid_q;
	logic [TDATA_W-1:0] out_data_q;
	logic               emit;
	logic [TDATA_W-1:0] emit_data;

	ggap_item_t       it;
	logic [LAT_W-1:0] lat_add;
	logic [LON_W-1:0] lon_add;
	logic             lat_short;
	logic             lon_short;
	logic [7:0]       cnt_inc;

	assign it  = head.item;
	assign pop = head.valid && (!out_valid_q || out_ready);

	// Digit contributions: each digit times the weight of its offset
	assign lat_add = LAT_W'({{(LAT_W-4){1'b0}}, it.digit} * lat_weight(fld_off_q));
	assign lon_add = LON_W'({{(LON_W-4){1'b0}}, it.digit} * lon_weight(fld_off_q));

	// A coordinate field closed before its format is complete
	assign lat_short = (fld_num_q == FLD_LAT) && (fld_off_q < LAT_LEN);
	assign lon_short = (fld_num_q == FLD_LON) && (fld_off_q < LON_LEN);
	assign cnt_inc   = byte_cnt_q + 8'd1;

	// Per-byte state update
	always_comb begin
		open_n     = open_q;
		byte_cnt_n = byte_cnt_q;
		fld_num_n  = fld_num_q;
		fld_off_n  = fld_off_q;
		type_ok_n  = type_ok_q;
		lat_acc_n  = lat_acc_q;
		lon_acc_n  = lon_acc_q;
		lat_ok_n   = lat_ok_q;
		lon_ok_n   = lon_ok_q;
		north_n    = north_q;
		east_n     = east_q;
		qual_n     = qual_q;
		emit       = 1'b0;
		emit_data  = '0;

		if (pop) begin
			if (it.is_dollar) begin
				// start or restart a sentence
				open_n     = 1'b1;
				byte_cnt_n = '0;
				fld_num_n  = '0;
				fld_off_n  = '0;
				type_ok_n  = 1'b0;
				lat_acc_n  = '0;
				lon_acc_n  = '0;
				lat_ok_n   = 1'b0;
				lon_ok_n   = 1'b0;
				north_n    = 1'b0;
				east_n     = 1'b0;
				qual_n     = FIX_NONE;
			end else if (open_q && it.is_eol) begin
				// end of sentence
				if (lat_short) lat_ok_n = 1'b0;
				if (lon_short) lon_ok_n = 1'b0;
				open_n = 1'b0;
				emit   = type_ok_q && (byte_cnt_q >= MIN_BYTES);
				emit_data[LAT_W-1:0]         = lat_ok_n ? lat_acc_q : '0;
				emit_data[26]                = lat_ok_n;
				emit_data[27]                = north_q;
				emit_data[28 +: LON_W]       = lon_ok_n ? lon_acc_q : '0;
				emit_data[58]                = lon_ok_n;
				emit_data[59]                = east_q;
				emit_data[61:60]             = qual_q;
			end else if (open_q) begin
				// sentence type letters
				if (byte_cnt_q == POS_T0) begin
					type_ok_n = it.is_g;
				end else if (byte_cnt_q == POS_T1) begin
					type_ok_n = type_ok_q && it.is_g;
				end else if (byte_cnt_q == POS_T2) begin
					type_ok_n = type_ok_q && it.is_a;
				end

				if (it.is_comma) begin
					if (lat_short) lat_ok_n = 1'b0;
					if (lon_short) lon_ok_n = 1'b0;
					if (fld_num_q != FLD_MAX) fld_num_n = fld_num_q + 4'd1;
					fld_off_n = '0;
					if (fld_num_n == FLD_LAT) lat_ok_n = 1'b1;
					if (fld_num_n == FLD_LON) lon_ok_n = 1'b1;
				end else begin
					priority if ((fld_num_q == FLD_LAT) && (fld_off_q < LAT_LEN)) begin
						if (fld_off_q == LAT_DOT) begin
							if (!it.is_dot) lat_ok_n = 1'b0;
						end else if (it.is_digit) begin
							lat_acc_n = lat_acc_q + lat_add;
						end else begin
							lat_ok_n = 1'b0;
						end
					end else if ((fld_num_q == FLD_LON) && (fld_off_q < LON_LEN)) begin
						if (fld_off_q == LON_DOT) begin
							if (!it.is_dot) lon_ok_n = 1'b0;
						end else if (it.is_digit) begin
							lon_acc_n = lon_acc_q + lon_add;
						end else begin
							lon_ok_n = 1'b0;
						end
					end else if (fld_off_q == '0) begin
						if ((fld_num_q == FLD_NS) && it.is_n) north_n = 1'b1;
						if ((fld_num_q == FLD_EW) && it.is_e) east_n = 1'b1;
						if (fld_num_q == FLD_QUAL) begin
							if (it.is_q1) qual_n = FIX_GPS;
							else if (it.is_q2) qual_n = FIX_DGPS;
						end
					end else begin
						qual_n = qual_q;
					end
					if (fld_off_q != FLD_MAX) fld_off_n = fld_off_q + 4'd1;
				end

				// overlong sentence is dropped
				byte_cnt_n = cnt_inc;
				if (cnt_inc >= MaxCnt) open_n = 1'b0;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			byte_cnt_q  <= '0;
			fld_num_q   <= '0;
			fld_off_q   <= '0;
			type_ok_q   <= 1'b0;
			lat_acc_q   <= '0;
			lon_acc_q   <= '0;
			lat_ok_q    <= 1'b0;
			lon_ok_q    <= 1'b0;
			north_q     <= 1'b0;
			east_q      <= 1'b0;
			qual_q      <= FIX_NONE;
			out_valid_q <= 1'b0;
		end else begin
			open_q     <= open_n;
			byte_cnt_q <= byte_cnt_n;
			fld_num_q  <= fld_num_n;
			fld_off_q  <= fld_off_n;
			type_ok_q  <= type_ok_n;
			lat_acc_q  <= lat_acc_n;
			lon_acc_q  <= lon_acc_n;
			lat_ok_q   <= lat_ok_n;
			lon_ok_q   <= lon_ok_n;
			north_q    <= north_n;
			east_q     <= east_n;
			qual_q     <= qual_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= emit_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> byte_cnt_q < MaxCnt)
		else $error("open sentence past the length limit");

	a_bad_lat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !emit_data[26]) |-> emit_data[LAT_W-1:0] == '0)
		else $error("malformed latitude reported nonzero");

	a_comma_resets_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && open_q && it.is_comma && !it.is_dollar) |=> fld_off_q == '0)
		else $error("field offset not cleared by comma");

	a_emit_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (open_q && type_ok_q) ##1 !open_q)
		else $error("result from a closed or non-GGA sentence");

endmodule

`default_nettype wire

>>> rtl/gga_sentence_position_parser.sv
// Top level of the GGA sentence position parser.
// Usage:
//   Input stream s_*: one received character per beat in s_tdata[7:0]; a NUL
//   beat is taken and ignored. '$' opens a sentence, CR or LF closes it.
//   Output stream m_*: one beat per closed GGA sentence carrying latitude and
//   longitude in minutes * 1e4, their ok flags, N/E flags and fix quality.
//   A closing byte accepted on s_* is first written into the queue, then the
//   back-end update sets m_tvalid through the output register.
//   Throughput: one byte per cycle unless the back end stops for a held result;
//   a 4-entry queue separates the byte classifier from the parser.
//   Stall: while m_tready is low the held result stays, the back end stops
//   and the queue fills; s_tready drops only when the queue is full.
//   Reset: arst_n clears framing state, the queue and the output valid; no
//   sentence is open after reset until a '$' arrives.
//   Sentences reaching MAX_SENTENCE stored bytes are dropped without result.
`default_nettype none

module gga_sentence_position_parser
	import ggap_pkg::*;
#(
	parameter int MAX_SENTENCE = MAX_SENTENCE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] rx_byte
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata    // [25:0] lat_minutes_e4, [26] lat_ok,
	                                           // [27] is_north, [57:28] lon_minutes_e4,
	                                           // [58] lon_ok, [59] is_east,
	                                           // [61:60] fix_quality, [63:62] zero
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	ggap_item_t q_item;
	ggap_head_t q_head;

	ggap_front u_front (
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (q_push),
		.item     (q_item)
	);

	ggap_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.full      (q_full),
		.head      (q_head)
	);

	ggap_back #(
		.MAX_SENTENCE (MAX_SENTENCE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

>>> bench/gga_fix_checker.sv
// Checker for the GGA parser: predicts position fixes from accepted bytes and compares them.
module gga_fix_checker
	import ggap_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [7:0]         s_tdata,          // [7:0] rx_byte
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	input  wire logic [TDATA_W-1:0] m_tdata,          // position fix, see gga_fix_t
	input  wire logic               run_done,
	output int                      errors,
	output int                      fixes_due,
	output int                      fixes_seen,
	output int                      fixes_predicted
);

	// Result beat layout, lowest field last
	typedef struct packed {
		logic [1:0]       quality;
		logic             east;
		logic             lon_ok;
		logic [LON_W-1:0] lon_e4;
		logic             north;
		logic             lat_ok;
		logic [LAT_W-1:0] lat_e4;
	} gga_fix_t;

	gga_fix_t fix_q[$];

	// Sentence framing and field tracking
	logic       in_sentence;
	logic [7:0] n_stored;
	logic [3:0] fld;
	logic [3:0] fld_pos;
	logic       gga_seen;
	logic       tail_checked;

	// Coordinates kept as whole degrees plus minutes * 1e4
	int         lat_deg, lat_min, lon_deg, lon_min;
	logic       lat_good, lon_good, north, east;
	logic [1:0] quality;

	function automatic bit is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	task automatic open_sentence();
		in_sentence = 1'b1;
		n_stored    = '0;
		fld         = '0;
		fld_pos     = '0;
		gga_seen    = 1'b0;
		lat_deg     = 0;
		lat_min     = 0;
		lon_deg     = 0;
		lon_min     = 0;
		lat_good    = 1'b0;
		lon_good    = 1'b0;
		north       = 1'b0;
		east        = 1'b0;
		quality     = FIX_NONE;
	endtask

	// A coordinate field that ends before its last digit is malformed
	task automatic end_field();
		if (fld == FLD_LAT && fld_pos < LAT_LEN)
			lat_good = 1'b0;
		if (fld == FLD_LON && fld_pos < LON_LEN)
			lon_good = 1'b0;
	endtask

	task automatic field_byte(input logic [7:0] b);
		int d;
		d = int'(b) - int'(CH_ZERO);
		if (fld == FLD_LAT && fld_pos < LAT_LEN) begin
			if (fld_pos == LAT_DOT) begin
				if (b != CH_DOT)
					lat_good = 1'b0;
			end else if (!is_digit(b)) begin
				lat_good = 1'b0;
			end else if (fld_pos < 2) begin
				lat_deg = lat_deg * 10 + d;
			end else begin
				lat_min = lat_min * 10 + d;
			end
		end else if (fld == FLD_LON && fld_pos < LON_LEN) begin
			if (fld_pos == LON_DOT) begin
				if (b != CH_DOT)
					lon_good = 1'b0;
			end else if (!is_digit(b)) begin
				lon_good = 1'b0;
			end else if (fld_pos < 3) begin
				lon_deg = lon_deg * 10 + d;
			end else begin
				lon_min = lon_min * 10 + d;
			end
		end else if (fld_pos == 0) begin
			// flags and quality look at the first character only
			if (fld == FLD_NS && b == CH_N)
				north = 1'b1;
			if (fld == FLD_EW && b == CH_E)
				east = 1'b1;
			if (fld == FLD_QUAL) begin
				if (b == CH_ONE)
					quality = FIX_GPS;
				else if (b == CH_TWO)
					quality = FIX_DGPS;
			end
		end
		if (fld_pos != FLD_MAX)
			fld_pos = fld_pos + 1'b1;
	endtask

	// Advance the parse by one accepted byte; a closed GGA sentence queues a fix
	task automatic take_byte(input logic [7:0] b);
		gga_fix_t fix;
		if (b == CH_DOLLAR) begin
			open_sentence();
		end else if (b != CH_NUL && in_sentence) begin
			if (b == CH_CR || b == CH_LF) begin
				end_field();
				in_sentence = 1'b0;
				if (gga_seen && n_stored >= MIN_BYTES) begin
					fix.lat_ok  = lat_good;
					fix.lat_e4  = lat_good ? LAT_W'(lat_deg * 600000 + lat_min) : '0;
					fix.north   = north;
					fix.lon_ok  = lon_good;
					fix.lon_e4  = lon_good ? LON_W'(lon_deg * 600000 + lon_min) : '0;
					fix.east    = east;
					fix.quality = quality;
					fix_q.push_back(fix);
					fixes_predicted++;
				end
			end else begin
				if (n_stored == POS_T0)
					gga_seen = (b == CH_G);
				else if (n_stored == POS_T1)
					gga_seen = gga_seen && (b == CH_G);
				else if (n_stored == POS_T2)
					gga_seen = gga_seen && (b == CH_A);
				if (b == CH_COMMA) begin
					end_field();
					if (fld != FLD_MAX)
						fld = fld + 1'b1;
					fld_pos = '0;
					if (fld == FLD_LAT)
						lat_good = 1'b1;
					if (fld == FLD_LON)
						lon_good = 1'b1;
				end else begin
					field_byte(b);
				end
				n_stored = n_stored + 1'b1;
				// overlong sentence is dropped
				if (int'(n_stored) >= MAX_SENTENCE_DEF)
					in_sentence = 1'b0;
			end
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: fix field %s mismatch: expected %0d, actual %0d",
				$time, name, want, got);
		end
	endtask

	task automatic check_fix(input logic [TDATA_W-1:0] beat);
		gga_fix_t want, got;
		got = beat[61:0];
		if (fix_q.size() == 0) begin
			errors++;
			$display("%0t: result beat with no fix expected: expected none, actual %h",
				$time, beat);
		end else begin
			want = fix_q.pop_front();
			fixes_seen++;
			check_field("lat_minutes_e4", want.lat_e4, got.lat_e4);
			check_field("lat_ok", want.lat_ok, got.lat_ok);
			check_field("is_north", want.north, got.north);
			check_field("lon_minutes_e4", want.lon_e4, got.lon_e4);
			check_field("lon_ok", want.lon_ok, got.lon_ok);
			check_field("is_east", want.east, got.east);
			check_field("fix_quality", want.quality, got.quality);
			check_field("pad bits", 0, beat[TDATA_W-1:62]);
		end
	endtask

	// Output beats are checked before the same edge's input beat is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_sentence();
			in_sentence = 1'b0;
			fix_q.delete();
			tail_checked = 1'b0;
			errors = 0;
			fixes_seen = 0;
			fixes_predicted = 0;
			fixes_due <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_fix(m_tdata);
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
			if (run_done && !tail_checked) begin
				tail_checked = 1'b1;
				if (fix_q.size() != 0) begin
					errors++;
					$display("%0t: fixes still expected at end: expected 0, actual %0d",
						$time, fix_q.size());
				end
			end
			fixes_due <= fix_q.size();
		end
	end

endmodule

>>> bench/tb_top.sv
// Testbench top for the GGA parser: sentence stimulus, flow control and verdict.
module tb_top;
	import ggap_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;      // [7:0] rx_byte
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;           // [25:0] lat, [26] lat_ok, [27] is_north,
	                                       // [57:28] lon, [58] lon_ok, [59] is_east,
	                                       // [61:60] fix_quality, [63:62] zero
	logic               run_done = 1'b0;

	int errors, fixes_due, fixes_seen, fixes_predicted;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_tickets = 0;
	int holds_done = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int body_bytes = 0;
	int sentences = 0;

	logic [7:0] line_q[$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	gga_sentence_position_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gga_fix_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.run_done        (run_done),
		.errors          (errors),
		.fixes_due       (fixes_due),
		.fixes_seen      (fixes_seen),
		.fixes_predicted (fixes_predicted)
	);

	// Receiver: random stalls, plus a long hold-off whenever one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_tickets) begin
			m_tready   <= 1'b0;
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic bit is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic bit ends_field(input logic [7:0] b);
		return b == CH_COMMA || b == CH_CR || b == CH_LF || b == CH_DOLLAR || b == CH_NUL;
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	// Any byte that stays inside the current field
	function automatic logic [7:0] pick_text_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (ends_field(b));
		return b;
	endfunction

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	// Coordinate with ndeg degree digits; broken ones are cut short or corrupted
	task automatic add_coord(input int ndeg, input bit broken);
		logic [7:0] f[$];
		int len, pos;
		logic [7:0] b;
		len = ndeg + 7;
		for (int i = 0; i < len; i++)
			f.push_back(i == ndeg + 2 ? CH_DOT : rand_digit());
		if (broken) begin
			case ($urandom_range(2))
				0: begin
					pos = $urandom_range(len - 1);
					while (f.size() > pos)
						void'(f.pop_back());
				end
				1: begin
					pos = $urandom_range(len - 1);
					do b = pick_text_byte();
					while (pos == ndeg + 2 ? b == CH_DOT : is_digit(b));
					f[pos] = b;
				end
				default: begin
					f[ndeg + 2] = rand_digit();
					f[$urandom_range(ndeg + 1)] = CH_DOT;
				end
			endcase
		end else if ($urandom_range(3) == 0) begin
			// extra precision, truncated by the parser
			repeat ($urandom_range(1, 4))
				f.push_back($urandom_range(3) == 0 ? pick_text_byte() : rand_digit());
		end
		foreach (f[i])
			line_q.push_back(f[i]);
	endtask

	task automatic add_flag(input logic [7:0] a, input logic [7:0] b);
		case ($urandom_range(9))
			0: ;
			1: line_q.push_back(pick_text_byte());
			2: begin
				line_q.push_back(a);
				line_q.push_back(b);
			end
			default: line_q.push_back($urandom_range(1) ? a : b);
		endcase
	endtask

	task automatic add_quality();
		case ($urandom_range(9))
			0: ;
			1: line_q.push_back(pick_text_byte());
			2: add_str("12");
			3: add_str("0");
			4: add_str("6");
			5, 6: line_q.push_back(CH_TWO);
			default: line_q.push_back(CH_ONE);
		endcase
	endtask

	// Sentence body after the dollar sign, terminator not included
	task automatic add_gga(input string head, input bit broken);
		int keep;
		add_str(head);
		repeat ($urandom_range(10))
			line_q.push_back($urandom_range(7) == 0 ? CH_DOT : rand_digit());
		line_q.push_back(CH_COMMA);
		add_coord(2, broken && $urandom_range(1));
		line_q.push_back(CH_COMMA);
		add_flag(CH_N, "S");
		line_q.push_back(CH_COMMA);
		add_coord(3, broken && $urandom_range(1));
		line_q.push_back(CH_COMMA);
		add_flag(CH_E, "W");
		line_q.push_back(CH_COMMA);
		add_quality();
		repeat ($urandom_range(6)) begin
			line_q.push_back(CH_COMMA);
			repeat ($urandom_range(4))
				line_q.push_back(rand_digit());
		end
		if ($urandom_range(1))
			add_str($sformatf("*%02X", $urandom_range(255)));
		// missing trailing fields
		if (broken && $urandom_range(2) == 0) begin
			keep = $urandom_range(2, line_q.size());
			while (line_q.size() > keep)
				void'(line_q.pop_back());
		end
	endtask

	task automatic add_end();
		case ($urandom_range(2))
			0: line_q.push_back(CH_CR);
			1: line_q.push_back(CH_LF);
			default: begin
				line_q.push_back(CH_CR);
				line_q.push_back(CH_LF);
			end
		endcase
	endtask

	// One beat per byte; the sender gaps at random, but valid holds until the beat is taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line(input bit counted);
		foreach (line_q[i]) begin
			if ($urandom_range(49) == 0)
				send_byte(CH_NUL);
			send_byte(line_q[i]);
		end
		if (counted) begin
			body_bytes += line_q.size();
			sentences++;
		end
		line_q.delete();
	endtask

	task automatic send_text(input string s);
		line_q.delete();
		add_str(s);
		send_line(1'b1);
	endtask

	// GGA sentence padded to a given stored length around the overflow limit
	task automatic send_long(input int stored);
		line_q.delete();
		line_q.push_back(CH_DOLLAR);
		add_gga("GPGGA,", 1'b0);
		while (line_q.size() < stored + 1)
			line_q.push_back($urandom_range(3) == 0 ? CH_COMMA : rand_digit());
		add_end();
		send_line(1'b1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (fixes_due != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_text("$GPGGA,123519,4807.0380,N,01131.0000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
		send_text("$GPGGA,000000,0000.0000,S,00000.0000,W,0\r");
		send_text("$GPGGA,235959,9999.9999,N,99999.9999,E,2\n");
		send_text("$GPGGA,,,,,,\r");
		send_text("$GPGGA\r");
		send_text("$GPGG\r$G\r");
		send_text("$GPGGA,1,48A7.0380,n,0113.10000,e,7\r");
		send_text("$GPGGA,1,480.70380,N,01131.000,E,1\r");
		send_text("$GPGGA,1,4807.038,N,01131.0000999,E,1*00\r");
		send_text("$GPGGA,1,4807.03801234,NS,17959.9999,EW,12\r");
		send_text("$GPRMC,1,4807.0380,N,01131.0000,E,1\r");
		// line endings and text with no sentence open
		send_text("\r\nxyz,\n");
		// dollar inside a sentence restarts it
		send_text("$GPGGA,1,4807.0$GPGGA,2,1234.5678,N,12345.6789,W,2\r");
		// NUL and high-bit bytes inside and after a sentence
		add_str("$GPGGA,1,4");
		line_q.push_back(8'hB9);
		add_str("07.0380,N,0");
		line_q.push_back(CH_NUL);
		add_str("1131.0000,E,1\r");
		line_q.push_back(8'hFF);
		line_q.push_back(8'h80);
		send_line(1'b1);
		// longest kept sentence, then the first dropped one
		send_long(MAX_SENTENCE_DEF - 1);
		send_long(MAX_SENTENCE_DEF);
	endtask

	task automatic make_sentence();
		int pick, n;
		string head;
		pick = $urandom_range(99);
		line_q.delete();
		if (pick < 4) begin
			// noise between sentences
			repeat ($urandom_range(1, 8))
				line_q.push_back($urandom_range(1) ? pick_text_byte() : 8'($urandom_range(255)));
			foreach (line_q[i])
				if (line_q[i] == CH_DOLLAR)
					line_q[i] = CH_CR;
			send_line(1'b0);
		end else if (pick < 6) begin
			send_long($urandom_range(MAX_SENTENCE_DEF - 4, MAX_SENTENCE_DEF + 3));
		end else begin
			line_q.push_back(CH_DOLLAR);
			if (pick < 12) begin
				case ($urandom_range(4))
					0: head = "GPRMC,";
					1: head = "GPGSA,";
					2: head = "GPGGB,";
					3: head = "GPXGA,";
					default: head = "GGA,";
				endcase
				add_gga(head, $urandom_range(1));
			end else if (pick < 17) begin
				// short sentence
				n = $urandom_range(5);
				head = "GPGGA";
				if (n != 0)
					add_str(head.substr(0, n - 1));
			end else begin
				if (pick < 22) begin
					// abandoned sentence, reopened by a new dollar
					add_str("GPGGA,");
					repeat ($urandom_range(12))
						line_q.push_back(rand_digit());
					line_q.push_back(CH_DOLLAR);
				end
				add_gga($urandom_range(3) == 0 ? "GNGGA," : "GPGGA,", pick < 40);
			end
			add_end();
			send_line(1'b1);
		end
	endtask

	initial begin : stimulus
		int goal;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 36 : (phase == 1 ? 75 : 0);
			recv_idle_pct = phase == 0 ? 75 : (phase == 1 ? 36 : 0);
			// sender pauses until every fix is out
			wait_drained();
			if (phase == 0)
				run_directed();
			if (phase == 2) begin
				// long output hold while a fix and more bytes are pushed in
				hold_tickets <= hold_tickets + 1;
				line_q.push_back(CH_DOLLAR);
				add_gga("GPGGA,", 1'b0);
				line_q.push_back(CH_CR);
				send_line(1'b1);
			end
			goal = 550 * (phase + 1);
			while (body_bytes < goal)
				make_sentence();
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		for (int k = 0; k < 5000 && fixes_due != 0; k++)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		run_done <= 1'b1;
		repeat (2)
			@(posedge clk);
		$display("Sent %0d bytes in %0d sentences; %0d position fixes checked",
			bytes_sent, sentences, fixes_seen);
		$display("Directed cases, sender- and receiver-side idling, no idling, one %0d-cycle hold",
			HOLD_CYCLES);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
